FILE: sv/alm_pkg.sv
// Shared constants, codes and controller/datapath structs for the attention
// logit engine. No dependencies; the files that use it refer to it by scoped name.
`default_nettype none

package alm_pkg;

   localparam int QUERY_ROWS = 8;
   localparam int KEY_ROWS   = 8;
   localparam int HEAD_WIDTH = 8;
   localparam int DATA_W     = 16;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int LOGIT_W    = 39;
   localparam int IDX_W      = 3;
   localparam int TYPE_W     = 2;
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int KEY_DEPTH  = KEY_ROWS * HEAD_WIDTH;
   localparam int BIAS_DEPTH = QUERY_ROWS * KEY_ROWS;

   localparam logic [IDX_W-1:0] LAST_HEAD = IDX_W'(HEAD_WIDTH - 1);
   localparam logic [IDX_W-1:0] LAST_KEY  = IDX_W'(KEY_ROWS - 1);

   // Request codes carried in req_type.
   localparam logic [TYPE_W-1:0] REQ_KEY   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_BIAS  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

   typedef struct packed {
      logic             wr_key;
      logic             wr_bias;
      logic             wr_query;
      logic             start;
      logic             issue;
      logic [IDX_W-1:0] k_idx;
      logic [IDX_W-1:0] h_idx;
      logic             load_rsp;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic sum_done;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/alm_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on alm_pkg for the field widths.
`default_nettype none

interface alm_req_if;
   logic                           valid;
   logic                           ready;
   logic [alm_pkg::TYPE_W-1:0]     req_type;
   logic [alm_pkg::IDX_W-1:0]      row_index;
   logic [alm_pkg::IDX_W-1:0]      col_index;
   logic signed [alm_pkg::DATA_W-1:0] element_value;

   modport source (output valid, req_type, row_index, col_index, element_value,
                   input ready);
   modport sink   (input valid, req_type, row_index, col_index, element_value,
                   output ready);
endinterface

interface alm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [alm_pkg::LOGIT_W-1:0] logit_value;
   logic [alm_pkg::IDX_W-1:0]          query_row;
   logic [alm_pkg::IDX_W-1:0]          key_row;
   logic                               last_of_row;

   modport source (output valid, logit_value, query_row, key_row, last_of_row,
                   input ready);
   modport sink   (input valid, logit_value, query_row, key_row, last_of_row,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/alm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module alm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/alm_ctrl.sv
// Sequencing state machine: takes request words, then steps through key rows
// and head indices for each logit. Depends on alm_pkg.
`default_nettype none

module alm_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [alm_pkg::TYPE_W-1:0]   req_type,
   input  wire logic [alm_pkg::IDX_W-1:0]    col_index,
   output logic                              req_ready,
   input  wire alm_pkg::status_type          status,
   output alm_pkg::cmd_type                  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [alm_pkg::IDX_W-1:0]   k_ff, k_in;
   logic [alm_pkg::IDX_W-1:0]   h_ff, h_in;
   logic                        accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      h_in         = h_ff;
      cmd          = '0;
      cmd.k_idx    = k_ff;
      cmd.h_idx    = h_ff;
      cmd.last     = (k_ff == alm_pkg::LAST_KEY);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.wr_key   = accept && (req_type == alm_pkg::REQ_KEY);
            cmd.wr_bias  = accept && (req_type == alm_pkg::REQ_BIAS);
            cmd.wr_query = accept && (req_type == alm_pkg::REQ_QUERY);
            // The final head element of a row starts the burst of logits.
            if (cmd.wr_query && (col_index == alm_pkg::LAST_HEAD)) begin
               cmd.start = 1'b1;
               k_in      = '0;
               h_in      = '0;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            h_in      = h_ff + 1'b1;
            if (h_ff == alm_pkg::LAST_HEAD) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.sum_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               h_in         = '0;
               if (k_ff == alm_pkg::LAST_KEY) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         h_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         h_ff     <= h_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/alm_dp.sv
// Datapath: key and bias stores, query row buffer, one pipelined
// multiply-accumulate unit and the result register. Depends on alm_pkg,
// alm_if and alm_ram.
`default_nettype none

module alm_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire alm_pkg::cmd_type                   cmd,
   output alm_pkg::status_type                     status,
   input  wire logic [alm_pkg::IDX_W-1:0]          row_index,
   input  wire logic [alm_pkg::IDX_W-1:0]          col_index,
   input  wire logic signed [alm_pkg::DATA_W-1:0]  element_value,
   alm_rsp_if.source                               rsp_chan
);

   localparam int DW = alm_pkg::DATA_W;
   localparam int PW = alm_pkg::PROD_W;
   localparam int LW = alm_pkg::LOGIT_W;
   localparam int IW = alm_pkg::IDX_W;

   logic [DW-1:0]          qbuf_ff [alm_pkg::HEAD_WIDTH];
   logic [IW-1:0]          qrow_ff;

   logic [DW-1:0]          key_rdata;
   logic [DW-1:0]          bias_rdata;
   logic                   bias_re;

   // Stage 1: RAM data visible.
   logic                   s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [IW-1:0]          s1_h_ff;
   // Stage 2: product registered.
   logic                   s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [DW-1:0]   bias_s2_ff;
   // Stage 3: running sum.
   logic signed [LW-1:0]   acc_ff, acc_in;
   logic                   done_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [LW-1:0]   rsp_logit_ff;
   logic [IW-1:0]          rsp_qrow_ff;
   logic [IW-1:0]          rsp_krow_ff;
   logic                   rsp_last_ff;

   assign bias_re = cmd.issue && (cmd.h_idx == '0);

   alm_ram #(.WIDTH(DW), .DEPTH(alm_pkg::KEY_DEPTH)) u_key_ram (
      .clock (clock),
      .we    (cmd.wr_key),
      .waddr ({row_index, col_index}),
      .wdata (element_value),
      .re    (cmd.issue),
      .raddr ({cmd.k_idx, cmd.h_idx}),
      .rdata (key_rdata)
   );

   alm_ram #(.WIDTH(DW), .DEPTH(alm_pkg::BIAS_DEPTH)) u_bias_ram (
      .clock (clock),
      .we    (cmd.wr_bias),
      .waddr ({row_index, col_index}),
      .wdata (element_value),
      .re    (bias_re),
      .raddr ({qrow_ff, cmd.k_idx}),
      .rdata (bias_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.wr_query) begin
         qbuf_ff[col_index] <= element_value;
      end
      if (cmd.start) begin
         qrow_ff <= row_index;
      end
   end

   assign prod_in = signed'(qbuf_ff[s1_h_ff]) * signed'(key_rdata);

   always_comb begin
      if (s2_first_ff) begin
         acc_in = LW'(bias_s2_ff) + LW'(prod_ff);
      end else begin
         acc_in = acc_ff + LW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff && s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (cmd.h_idx == '0);
      s1_last_ff  <= (cmd.h_idx == alm_pkg::LAST_HEAD);
      s1_h_ff     <= cmd.h_idx;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      if (s1_valid_ff) begin
         prod_ff <= prod_in;
      end
      if (s1_valid_ff && s1_first_ff) begin
         bias_s2_ff <= bias_rdata;
      end
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Result register: holds one word until the sink takes it.
   assign status.rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign status.sum_done = done_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_logit_ff <= acc_ff;
         rsp_qrow_ff  <= qrow_ff;
         rsp_krow_ff  <= cmd.k_idx;
         rsp_last_ff  <= cmd.last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.logit_value = rsp_logit_ff;
   assign rsp_chan.query_row   = rsp_qrow_ff;
   assign rsp_chan.key_row     = rsp_krow_ff;
   assign rsp_chan.last_of_row = rsp_last_ff;

endmodule

`default_nettype wire

FILE: sv/attention_logit_matmul_bias_top.sv
// Top level of the attention logit engine: controller plus datapath.
// Depends on alm_pkg, alm_if, alm_ram, alm_ctrl and alm_dp.
//
// The block computes logit[q][k] = bias[q][k] + sum over h of
// query[q][h] * key[k][h] for an 8 x 8 key store, an 8 x 8 bias store and
// 8 head elements, all signed 16-bit. A request word with req_type key or
// bias writes one element into its store, and so does a query word that is
// not the last head element of its row. A query word with col_index equal to
// the last head index completes the row and produces a burst of eight result
// words, one per key row in key order, the last one flagged with last_of_row.
// The bias is taken from the row of that completing word, and query_row
// reports that row. Each logit is formed by one shared multiply-accumulate
// unit fed from the single read port of the key store, one head element per
// cycle: eight key reads, then the pipeline drains and the sum is loaded into
// the result register once that is free. The burst holds the request channel
// until its last result word is loaded. Sums are exact and reported in 39 bits
// without saturation. A word whose req_type is unused is accepted and dropped.
// Reading a store entry that was never written returns whatever the memory
// holds. The result register lets the next request word be accepted while the
// final logit still waits.
`default_nettype none

module attention_logit_matmul_bias_top (
   input  wire logic clock,
   input  wire logic reset,
   alm_req_if.sink   req_chan,
   alm_rsp_if.source rsp_chan
);

   alm_pkg::cmd_type    cmd;
   alm_pkg::status_type status;

   alm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .col_index (req_chan.col_index),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   alm_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .row_index     (req_chan.row_index),
      .col_index     (req_chan.col_index),
      .element_value (req_chan.element_value),
      .rsp_chan      (rsp_chan)
   );

endmodule

`default_nettype wire
